// ----- hdl/tccc_pkg.sv -----
// shared types and constants for the two-core coherent cache
// no dependencies; used by every module of the block but tccc_ram
package tccc_pkg;

  localparam int CORES           = 2;
  localparam int LINES_PER_CACHE = 2;
  localparam int WORDS_PER_LINE  = 2;
  localparam int MEM_WORDS       = 128;

  localparam int DATA_W   = 16;
  localparam int ADDR_W   = 7;
  localparam int CORE_W   = 1;
  localparam int IDX_W    = 1;
  localparam int OFF_W    = 1;
  localparam int BASE_W   = ADDR_W - OFF_W;
  localparam int CWORDS   = CORES * LINES_PER_CACHE * WORDS_PER_LINE;
  localparam int CADDR_W  = CORE_W + IDX_W + OFF_W;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // where the word came from
  typedef enum logic [1:0] {
    SRV_OWN    = 2'd0,
    SRV_REMOTE = 2'd1,
    SRV_MEM    = 2'd2
  } served_t;

  // mesi line states
  typedef enum logic [1:0] {
    LS_INVALID   = 2'd0,
    LS_SHARED    = 2'd1,
    LS_EXCLUSIVE = 2'd2,
    LS_MODIFIED  = 2'd3
  } line_state_t;

  // access sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_RD_WAIT,
    ST_WB_RD,
    ST_WB_WR,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               we;
    logic [CADDR_W-1:0] addr;
    logic [DATA_W-1:0]  wdata;
  } cram_req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mram_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    served_t                  served_from;
    logic                     wrote_back;
  } result_t;

endpackage

// ----- hdl/tccc_ram.sv -----
// generic single-port synchronous ram with registered read
// no dependencies; holds the cache line words
module tccc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and registered read of the addressed word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hdl/tccc_main_mem.sv -----
// shared word memory with per-word written flags so reset reads as zero
// depends on tccc_pkg
module tccc_main_mem (
  input  logic                              clk,
  input  logic                              rst,
  input  tccc_pkg::mram_req_t               req,
  output logic [tccc_pkg::DATA_W-1:0]       rdata
);

  logic [tccc_pkg::DATA_W-1:0] mem [tccc_pkg::MEM_WORDS];
  logic [tccc_pkg::MEM_WORDS-1:0] written;
  logic [tccc_pkg::DATA_W-1:0] rd_q;
  logic                        rd_vld;

  // storage array
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rd_q <= mem[req.addr];
  end

  // written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (req.we) begin
        written[req.addr] <= 1'b1;
      end
      rd_vld <= written[req.addr];
    end
  end

  // never written words read as zero
  assign rdata = rd_vld ? rd_q : '0;

endmodule

// ----- hdl/tccc_ctrl.sv -----
// access sequencer and mesi directory (state and base of every line)
// depends on tccc_pkg; drives the line ram and the shared memory
module tccc_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic                                req_op,
  input  logic [tccc_pkg::CORE_W-1:0]         req_core,
  input  logic [tccc_pkg::ADDR_W-1:0]         req_addr,
  input  logic [tccc_pkg::DATA_W-1:0]         req_wdata,
  output tccc_pkg::cram_req_t                 cram,
  input  logic [tccc_pkg::DATA_W-1:0]         cram_rdata,
  output tccc_pkg::mram_req_t                 mram,
  input  logic [tccc_pkg::DATA_W-1:0]         mram_rdata,
  output logic                                res_valid,
  input  logic                                res_take,
  output tccc_pkg::result_t                   res
);

  tccc_pkg::state_t state, state_next;

  // latched request
  logic                          op;
  logic [tccc_pkg::CORE_W-1:0]   core;
  logic [tccc_pkg::ADDR_W-1:0]   addr;
  logic [tccc_pkg::DATA_W-1:0]   wdata;

  // directory
  tccc_pkg::line_state_t        stat [tccc_pkg::CORES][tccc_pkg::LINES_PER_CACHE];
  logic [tccc_pkg::BASE_W-1:0]  base [tccc_pkg::CORES][tccc_pkg::LINES_PER_CACHE];

  // per-access working registers
  logic [tccc_pkg::CORE_W-1:0]  hold;
  tccc_pkg::served_t            served;
  logic                         wb;
  logic [tccc_pkg::OFF_W-1:0]   cnt;
  logic [tccc_pkg::DATA_W-1:0]  data;

  logic [tccc_pkg::IDX_W-1:0]   idx;
  logic [tccc_pkg::OFF_W-1:0]   off;
  logic [tccc_pkg::BASE_W-1:0]  tag;
  logic [tccc_pkg::CORES-1:0]   holds;
  logic [tccc_pkg::CORE_W-1:0]  hold_lk;
  tccc_pkg::served_t            served_lk;
  logic                         cnt_last;

  assign off = addr[tccc_pkg::OFF_W-1:0];
  assign idx = addr[tccc_pkg::OFF_W +: tccc_pkg::IDX_W];
  assign tag = addr[tccc_pkg::ADDR_W-1:tccc_pkg::OFF_W];
  assign cnt_last = (cnt == tccc_pkg::OFF_W'(tccc_pkg::WORDS_PER_LINE - 1));

  // snoop every core for the line; the own core wins, else the lowest holder wins
  always_comb begin
    hold_lk = core;
    for (int c = 0; c < tccc_pkg::CORES; c++) begin
      holds[c] = (stat[c][idx] != tccc_pkg::LS_INVALID) && (base[c][idx] == tag);
    end
    for (int c = tccc_pkg::CORES - 1; c >= 0; c--) begin
      if (holds[c]) begin
        hold_lk = tccc_pkg::CORE_W'(c);
      end
    end
    if (holds[core]) begin
      served_lk = tccc_pkg::SRV_OWN;
      hold_lk   = core;
    end else if (holds != '0) begin
      served_lk = tccc_pkg::SRV_REMOTE;
    end else begin
      served_lk = tccc_pkg::SRV_MEM;
      hold_lk   = core;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tccc_pkg::ST_IDLE: begin
        if (req_valid) state_next = tccc_pkg::ST_LOOK;
      end
      tccc_pkg::ST_LOOK: begin
        if (served_lk != tccc_pkg::SRV_MEM) begin
          state_next = (op == tccc_pkg::OP_READ) ? tccc_pkg::ST_RD_WAIT : tccc_pkg::ST_OUT;
        end else if (stat[core][idx] == tccc_pkg::LS_MODIFIED) begin
          state_next = tccc_pkg::ST_WB_RD;
        end else begin
          state_next = tccc_pkg::ST_FILL_RD;
        end
      end
      tccc_pkg::ST_RD_WAIT: state_next = tccc_pkg::ST_OUT;
      tccc_pkg::ST_WB_RD:   state_next = tccc_pkg::ST_WB_WR;
      tccc_pkg::ST_WB_WR: begin
        state_next = cnt_last ? tccc_pkg::ST_FILL_RD : tccc_pkg::ST_WB_RD;
      end
      tccc_pkg::ST_FILL_RD: state_next = tccc_pkg::ST_FILL_WR;
      tccc_pkg::ST_FILL_WR: begin
        state_next = cnt_last ? tccc_pkg::ST_OUT : tccc_pkg::ST_FILL_RD;
      end
      tccc_pkg::ST_OUT: begin
        if (res_take) state_next = tccc_pkg::ST_IDLE;
      end
      default: state_next = tccc_pkg::ST_IDLE;
    endcase
  end

  // memory requests and handshake outputs
  always_comb begin
    cram      = '0;
    mram      = '0;
    req_ready = (state == tccc_pkg::ST_IDLE) && !rst;
    res_valid = (state == tccc_pkg::ST_OUT);
    case (state)
      tccc_pkg::ST_LOOK: begin
        cram.addr = {hold_lk, idx, off};
        if (served_lk != tccc_pkg::SRV_MEM && op == tccc_pkg::OP_WRITE) begin
          cram.we    = 1'b1;
          cram.wdata = wdata;
        end
      end
      tccc_pkg::ST_WB_RD: begin
        cram.addr = {core, idx, cnt};
      end
      tccc_pkg::ST_WB_WR: begin
        mram.we    = 1'b1;
        mram.addr  = {base[core][idx], cnt};
        mram.wdata = cram_rdata;
      end
      tccc_pkg::ST_FILL_RD: begin
        mram.addr = {tag, cnt};
      end
      tccc_pkg::ST_FILL_WR: begin
        cram.we    = 1'b1;
        cram.addr  = {core, idx, cnt};
        cram.wdata = (op == tccc_pkg::OP_WRITE && cnt == off) ? wdata : mram_rdata;
      end
      default: begin
      end
    endcase
  end

  assign res.read_data   = data;
  assign res.served_from = served;
  assign res.wrote_back  = wb;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tccc_pkg::ST_IDLE;
      for (int c = 0; c < tccc_pkg::CORES; c++) begin
        for (int l = 0; l < tccc_pkg::LINES_PER_CACHE; l++) begin
          stat[c][l] <= tccc_pkg::LS_INVALID;
          base[c][l] <= '0;
        end
      end
    end else begin
      state <= state_next;
      // directory updates
      if (state == tccc_pkg::ST_LOOK && served_lk != tccc_pkg::SRV_MEM) begin
        if (op == tccc_pkg::OP_READ) begin
          if (served_lk == tccc_pkg::SRV_REMOTE) stat[hold_lk][idx] <= tccc_pkg::LS_SHARED;
        end else begin
          for (int c = 0; c < tccc_pkg::CORES; c++) begin
            if (served_lk == tccc_pkg::SRV_REMOTE && holds[c] &&
                tccc_pkg::CORE_W'(c) != hold_lk) begin
              stat[c][idx] <= tccc_pkg::LS_INVALID;
            end
          end
          stat[hold_lk][idx] <= tccc_pkg::LS_MODIFIED;
        end
      end
      if (state == tccc_pkg::ST_FILL_WR && cnt_last) begin
        stat[core][idx] <= (op == tccc_pkg::OP_WRITE) ? tccc_pkg::LS_MODIFIED
                                                      : tccc_pkg::LS_EXCLUSIVE;
        base[core][idx] <= tag;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    case (state)
      tccc_pkg::ST_IDLE: begin
        op    <= req_op;
        core  <= req_core;
        addr  <= req_addr;
        wdata <= req_wdata;
      end
      tccc_pkg::ST_LOOK: begin
        hold   <= hold_lk;
        served <= served_lk;
        cnt    <= '0;
        wb     <= (served_lk == tccc_pkg::SRV_MEM) &&
                  (stat[core][idx] == tccc_pkg::LS_MODIFIED);
        data   <= wdata;
      end
      tccc_pkg::ST_RD_WAIT: begin
        data <= cram_rdata;
      end
      tccc_pkg::ST_WB_WR: begin
        cnt <= cnt_last ? '0 : cnt + 1'b1;
      end
      tccc_pkg::ST_FILL_WR: begin
        if (cnt == off && op == tccc_pkg::OP_READ) data <= mram_rdata;
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // a victim write-back only happens on a memory fill
  a_wb_only_on_fill: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res.wrote_back || res.served_from == tccc_pkg::SRV_MEM))
    else $error("write-back reported without a memory fill");

  // a finished write leaves the holder's line modified
  a_write_leaves_modified: assert property (@(posedge clk) disable iff (rst)
    (res_valid && op == tccc_pkg::OP_WRITE) |-> (stat[hold][idx] == tccc_pkg::LS_MODIFIED))
    else $error("write finished without a modified line");

  // a finished read leaves its source line valid with the right base
  a_read_line_valid: assert property (@(posedge clk) disable iff (rst)
    (res_valid && op == tccc_pkg::OP_READ) |->
      (stat[hold][idx] != tccc_pkg::LS_INVALID && base[hold][idx] == tag))
    else $error("read finished on an invalid line");

  // write-back only drains a modified victim
  a_wb_from_modified: assert property (@(posedge clk) disable iff (rst)
    (state == tccc_pkg::ST_WB_RD) |-> (stat[core][idx] == tccc_pkg::LS_MODIFIED))
    else $error("write-back of a line that is not modified");

endmodule

// ----- hdl/two_core_coherent_cache.sv -----
// top level of the two-core mesi snooping cache with shared word memory
// depends on tccc_pkg, tccc_ram, tccc_main_mem and tccc_ctrl
//
//  channel   dir  beat fields
//  s_axis    in   tdata: word_address, write_data; tuser: op, core_id
//  m_axis    out  tdata: read_data; tuser: served_from, wrote_back
//
// one access at a time; a read hit (own or remote) passes look, read wait and output,
// a write hit passes look and output, and a miss fills the line word by word from the
// shared memory, first writing back a modified victim word by word, as each word must
// pass the single port of the line ram and of the shared memory. reset clears every
// line to invalid and makes the shared memory read as zero at once. the result waits
// in an output register, so a stalled m_axis holds only the sequencer's last step.
module two_core_coherent_cache (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // word_address[6:0], write_data[22:7], zero pad
  input  logic [1:0]  s_axis_tuser,   // op[0], core_id[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // read_data[15:0]
  output logic [2:0]  m_axis_tuser    // served_from[1:0], wrote_back[2]
);

  tccc_pkg::cram_req_t          cram;
  tccc_pkg::mram_req_t          mram;
  logic [tccc_pkg::DATA_W-1:0]  cram_rdata;
  logic [tccc_pkg::DATA_W-1:0]  mram_rdata;
  logic                         res_valid;
  logic                         res_take;
  tccc_pkg::result_t            res;
  tccc_pkg::result_t            out_q;

  // cache line words of all cores
  tccc_ram #(
    .WIDTH (tccc_pkg::DATA_W),
    .DEPTH (tccc_pkg::CWORDS)
  ) u_lines (
    .clk   (clk),
    .we    (cram.we),
    .addr  (cram.addr),
    .wdata (cram.wdata),
    .rdata (cram_rdata)
  );

  // shared word memory
  tccc_main_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mram),
    .rdata (mram_rdata)
  );

  // sequencer and directory
  tccc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (s_axis_tvalid),
    .req_ready  (s_axis_tready),
    .req_op     (s_axis_tuser[0]),
    .req_core   (s_axis_tuser[1]),
    .req_addr   (s_axis_tdata[6:0]),
    .req_wdata  (s_axis_tdata[22:7]),
    .cram       (cram),
    .cram_rdata (cram_rdata),
    .mram       (mram),
    .mram_rdata (mram_rdata),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  // output register loads when empty or being drained
  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = out_q.read_data;
  assign m_axis_tuser = {out_q.wrote_back, out_q.served_from};

endmodule
